// ----- src/ogr_pkg.sv -----
package ogr_pkg;

	localparam int GRID_COLS = 256;
	localparam int GRID_ROWS = 256;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam int COORD_W = 8;
	localparam int VAL_W = 16;
	localparam int CNT_W = 8;
	localparam int ERR_W = COORD_W + 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam logic KIND_RAY = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam cfg_idx_t CFG_FREE_INC = 2'd0;
	localparam cfg_idx_t CFG_OCC_INC = 2'd1;
	localparam cfg_idx_t CFG_LOWER = 2'd2;
	localparam cfg_idx_t CFG_UPPER = 2'd3;

	localparam val_t FREE_INC_RST = -16'sd217;
	localparam val_t OCC_INC_RST = 16'sd217;
	localparam val_t LOWER_RST = -16'sd2048;
	localparam val_t UPPER_RST = 16'sd2048;

	typedef struct packed {
		logic load;
		logic step;
		logic walk_rd;
		logic cell_rd;
		logic clr_wr;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
		logic clr_last;
	} sts_t;

endpackage

// ----- src/ogr_in_if.sv -----
interface ogr_in_if;
	logic valid;
	logic ready;
	logic kind;
	ogr_pkg::coord_t col_a;
	ogr_pkg::coord_t row_a;
	ogr_pkg::coord_t col_b;
	ogr_pkg::coord_t row_b;
	logic is_hit;

	modport source (output valid, kind, col_a, row_a, col_b, row_b, is_hit, input ready);
	modport sink (input valid, kind, col_a, row_a, col_b, row_b, is_hit, output ready);
endinterface

// ----- src/ogr_out_if.sv -----
interface ogr_out_if;
	logic valid;
	logic ready;
	ogr_pkg::val_t cell_value;
	ogr_pkg::cnt_t cells_updated;

	modport source (output valid, cell_value, cells_updated, input ready);
	modport sink (input valid, cell_value, cells_updated, output ready);
endinterface

// ----- src/ogr_ram.sv -----
module ogr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/ogr_ctrl.sv -----
module ogr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_kind,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ogr_pkg::sts_t sts,
	output ogr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		PRIME,
		WALK,
		RD,
		FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			CLEAR: cmd.clr_wr = 1'b1;
			IDLE:  cmd.load = in_valid;
			PRIME: cmd.step = !sts.skip;
			WALK: begin
				cmd.step = 1'b1;
				cmd.walk_rd = 1'b1;
			end
			RD:    cmd.cell_rd = 1'b1;
			FIN:   cmd.put = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	assign in_ready = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					if (sts.clr_last) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (in_valid) begin
						state_q <= (in_kind == ogr_pkg::KIND_READ) ? RD : PRIME;
					end
				end
				PRIME: state_q <= sts.skip ? FIN : WALK;
				WALK: begin
					if (sts.last) begin
						state_q <= FIN;
					end
				end
				RD: state_q <= FIN;
				FIN: begin
					if (cmd.put) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- src/ogr_datapath.sv -----
module ogr_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  ogr_pkg::cfg_idx_t cfg_index,
	input  ogr_pkg::val_t     cfg_data,
	input  logic              in_kind,
	input  ogr_pkg::coord_t   in_col_a,
	input  ogr_pkg::coord_t   in_row_a,
	input  ogr_pkg::coord_t   in_col_b,
	input  ogr_pkg::coord_t   in_row_b,
	input  logic              in_is_hit,
	output ogr_pkg::val_t     cell_value,
	output ogr_pkg::cnt_t     cells_updated,
	input  ogr_pkg::cmd_t     cmd,
	output ogr_pkg::sts_t     sts
);

	ogr_pkg::val_t   free_inc_q, occ_inc_q, lower_q, upper_q;
	ogr_pkg::coord_t col_q, row_q, end_col_q, end_row_q, dc_q, dr_q;
	logic            col_neg_q, row_neg_q, hit_q, read_q, a_in_q, b_in_q;
	ogr_pkg::err_t   err_q;
	ogr_pkg::cnt_t   cnt_q;
	ogr_pkg::addr_t  clr_q;
	logic            wr_v_s1;
	ogr_pkg::addr_t  addr_s1;
	ogr_pkg::val_t   inc_s1;
	ogr_pkg::val_t   cell_value_q;
	ogr_pkg::cnt_t   cells_updated_q;

	ogr_pkg::addr_t  addr_now;
	ogr_pkg::val_t   rdata;
	ogr_pkg::val_t   wdata_sat;
	logic            we;
	ogr_pkg::addr_t  waddr;
	ogr_pkg::val_t   wdata;
	logic            at_end;
	logic signed [ogr_pkg::ERR_W:0]   e2, dc_w, dr_w;
	logic                             step_c, step_r;
	ogr_pkg::err_t                    err_n;
	logic signed [ogr_pkg::VAL_W:0]   sum, clamp;
	ogr_pkg::coord_t                  dc_in, dr_in;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_inc_q <= ogr_pkg::FREE_INC_RST;
			occ_inc_q <= ogr_pkg::OCC_INC_RST;
			lower_q <= ogr_pkg::LOWER_RST;
			upper_q <= ogr_pkg::UPPER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ogr_pkg::CFG_FREE_INC: free_inc_q <= cfg_data;
				ogr_pkg::CFG_OCC_INC:  occ_inc_q <= cfg_data;
				ogr_pkg::CFG_LOWER:    lower_q <= cfg_data;
				ogr_pkg::CFG_UPPER:    upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dc_in = (in_col_b > in_col_a) ? in_col_b - in_col_a : in_col_a - in_col_b;
	assign dr_in = (in_row_b > in_row_a) ? in_row_b - in_row_a : in_row_a - in_row_b;

	// bresenham step
	assign e2 = {err_q, 1'b0};
	assign dc_w = $signed({4'b0, dc_q});
	assign dr_w = $signed({4'b0, dr_q});
	assign step_c = e2 > -dr_w;
	assign step_r = e2 < dc_w;
	assign err_n = err_q - (step_c ? dr_w[ogr_pkg::ERR_W-1:0] : '0)
		+ (step_r ? dc_w[ogr_pkg::ERR_W-1:0] : '0);

	assign at_end = (col_q == end_col_q) && (row_q == end_row_q);
	assign addr_now = ogr_pkg::ADDR_W'(row_q) * ogr_pkg::ADDR_W'(ogr_pkg::GRID_COLS)
		+ ogr_pkg::ADDR_W'(col_q);

	assign sts.skip = !a_in_q || !b_in_q || at_end;
	assign sts.last = at_end;
	assign sts.clr_last = (clr_q == ogr_pkg::ADDR_W'(ogr_pkg::GRID_CELLS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= in_col_a;
			row_q <= in_row_a;
			end_col_q <= in_col_b;
			end_row_q <= in_row_b;
			hit_q <= in_is_hit;
			read_q <= (in_kind == ogr_pkg::KIND_READ);
			dc_q <= dc_in;
			dr_q <= dr_in;
			col_neg_q <= !(in_col_a < in_col_b);
			row_neg_q <= !(in_row_a < in_row_b);
			err_q <= ogr_pkg::ERR_W'(dc_in) - ogr_pkg::ERR_W'(dr_in);
			a_in_q <= (int'(in_col_a) < ogr_pkg::GRID_COLS)
				&& (int'(in_row_a) < ogr_pkg::GRID_ROWS);
			b_in_q <= (int'(in_col_b) < ogr_pkg::GRID_COLS)
				&& (int'(in_row_b) < ogr_pkg::GRID_ROWS);
			cnt_q <= '0;
		end else begin
			if (cmd.step) begin
				err_q <= err_n;
				if (step_c) begin
					col_q <= col_neg_q ? col_q - 1'b1 : col_q + 1'b1;
				end
				if (step_r) begin
					row_q <= row_neg_q ? row_q - 1'b1 : row_q + 1'b1;
				end
			end
			if (cmd.walk_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
		addr_s1 <= addr_now;
		inc_s1 <= (at_end && hit_q) ? occ_inc_q : free_inc_q;
		if (cmd.put) begin
			cell_value_q <= (read_q && a_in_q) ? rdata : '0;
			cells_updated_q <= read_q ? '0 : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
			clr_q <= '0;
		end else begin
			wr_v_s1 <= cmd.walk_rd;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// saturating add of the read cell
	always_comb begin
		sum = $signed({rdata[ogr_pkg::VAL_W-1], rdata}) + $signed({inc_s1[ogr_pkg::VAL_W-1], inc_s1});
		clamp = sum;
		if (clamp > $signed({upper_q[ogr_pkg::VAL_W-1], upper_q})) begin
			clamp = $signed({upper_q[ogr_pkg::VAL_W-1], upper_q});
		end
		if (clamp < $signed({lower_q[ogr_pkg::VAL_W-1], lower_q})) begin
			clamp = $signed({lower_q[ogr_pkg::VAL_W-1], lower_q});
		end
		wdata_sat = clamp[ogr_pkg::VAL_W-1:0];
	end

	assign we = cmd.clr_wr || wr_v_s1;
	assign waddr = cmd.clr_wr ? clr_q : addr_s1;
	assign wdata = cmd.clr_wr ? '0 : wdata_sat;

	ogr_ram #(
		.WIDTH(ogr_pkg::VAL_W),
		.DEPTH(ogr_pkg::GRID_CELLS)
	) u_grid (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(cmd.walk_rd || cmd.cell_rd),
		.raddr(addr_now),
		.rdata(rdata)
	);

	assign cell_value = cell_value_q;
	assign cells_updated = cells_updated_q;

endmodule

// ----- src/occupancy_grid_ray_update.sv -----
// Log-odds occupancy grid with Bresenham ray updates, Q7.8 cells.
// req carries one item per transfer: kind selects a ray update or a cell read.
// A ray walks from (col_a,row_a) to (col_b,row_b), skipping the start cell,
// adding free_increment to each cell, or occupied_increment to the end cell
// on a hit, saturating into [lower_limit, upper_limit].
// rsp returns exactly one result per item: cell_value for a read,
// cells_updated for a ray.
// Each ray cell is one read-modify-write of the single-port-pair grid memory,
// one cell per cycle. A ray passes PRIME, then WALK, then FIN, where its
// result is put in the output register; the next item is taken only after
// that, back in IDLE. Reads pass RD and FIN, skipped rays PRIME and FIN.
// After reset the grid is cleared one cell a cycle, all GRID_COLS*GRID_ROWS
// cells (65536), with req.ready low; configuration writes are taken anyway.
// The result sits in an output register: the block takes the next item while
// it waits, and holds the following result until rsp.ready frees the register.
// User writes configuration (cfg_we, cfg_index 0..3) while idle; not enforced.
module occupancy_grid_ray_update (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  ogr_pkg::cfg_idx_t cfg_index,
	input  ogr_pkg::val_t     cfg_data,
	ogr_in_if.sink            req,
	ogr_out_if.source         rsp
);

	ogr_pkg::cmd_t cmd;
	ogr_pkg::sts_t sts;

	ogr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_kind(req.kind),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts(sts),
		.cmd(cmd)
	);

	ogr_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_kind(req.kind),
		.in_col_a(req.col_a),
		.in_row_a(req.row_a),
		.in_col_b(req.col_b),
		.in_row_b(req.row_b),
		.in_is_hit(req.is_hit),
		.cell_value(rsp.cell_value),
		.cells_updated(rsp.cells_updated),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import ogr_pkg::*;

	localparam int ITEMS_PER_PHASE = 120;
	localparam int RSP_HOLD_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		logic   kind;
		coord_t col_a;
		coord_t row_a;
		coord_t col_b;
		coord_t row_b;
		logic   is_hit;
	} grid_req_t;

	typedef struct packed {
		val_t cell_value;
		cnt_t cells_updated;
	} grid_rsp_t;

	class grid_tracker;
		val_t      cells [GRID_CELLS];
		int        free_inc;
		int        occ_inc;
		int        lo_lim;
		int        hi_lim;
		grid_rsp_t pending_rsp[$];
		int        errors;
		int        rays;
		int        hits;
		int        flat_rays;
		int        reads;
		int        clamps;
		int        longest;

		function new();
			foreach (cells[i]) cells[i] = '0;
			free_inc = FREE_INC_RST;
			occ_inc = OCC_INC_RST;
			lo_lim = LOWER_RST;
			hi_lim = UPPER_RST;
			errors = 0;
			rays = 0;
			hits = 0;
			flat_rays = 0;
			reads = 0;
			clamps = 0;
			longest = 0;
		endfunction

		function void set_register(cfg_idx_t idx, val_t value);
			case (idx)
				CFG_FREE_INC: free_inc = value;
				CFG_OCC_INC:  occ_inc = value;
				CFG_LOWER:    lo_lim = value;
				CFG_UPPER:    hi_lim = value;
				default: ;
			endcase
		endfunction

		function void bump(int col, int row, int inc);
			int  idx;
			int  v;
			bit  sat;
			idx = row * GRID_COLS + col;
			v = int'(cells[idx]) + inc;
			sat = 0;
			if (v > hi_lim) begin
				v = hi_lim;
				sat = 1;
			end
			if (v < lo_lim) begin
				v = lo_lim;
				sat = 1;
			end
			if (sat) clamps++;
			cells[idx] = val_t'(v);
		endfunction

		function void note_request(grid_req_t rq);
			grid_rsp_t res;
			int        c0, r0, c1, r1;
			int        dc, dr, sc, sr, err, e2, c, r, n;
			bit        last;
			res = '0;
			c0 = rq.col_a;
			r0 = rq.row_a;
			c1 = rq.col_b;
			r1 = rq.row_b;
			if (rq.kind == KIND_READ) begin
				reads++;
				res.cell_value = cells[r0 * GRID_COLS + c0];
			end else if (c0 == c1 && r0 == r1) begin
				flat_rays++;
			end else begin
				dc = (c1 > c0) ? c1 - c0 : c0 - c1;
				dr = (r1 > r0) ? r1 - r0 : r0 - r1;
				sc = (c0 < c1) ? 1 : -1;
				sr = (r0 < r1) ? 1 : -1;
				err = dc - dr;
				c = c0;
				r = r0;
				n = 0;
				while (1) begin
					e2 = 2 * err;
					if (e2 > -dr) begin
						err -= dr;
						c += sc;
					end
					if (e2 < dc) begin
						err += dc;
						r += sr;
					end
					last = (c == c1 && r == r1);
					bump(c, r, (last && rq.is_hit) ? occ_inc : free_inc);
					n++;
					if (last) break;
				end
				res.cells_updated = cnt_t'(n);
				rays++;
				if (rq.is_hit) hits++;
				if (n > longest) longest = n;
			end
			pending_rsp = {pending_rsp, res};
		endfunction

		function void check_response(val_t cv, cnt_t cu);
			grid_rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("result with nothing pending: cell_value %0d cells_updated %0d",
					$signed(cv), cu);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (cv !== want.cell_value) begin
				$error("cell_value mismatch: expected %0d, actual %0d",
					$signed(want.cell_value), $signed(cv));
				errors++;
			end
			if (cu !== want.cells_updated) begin
				$error("cells_updated mismatch: expected %0d, actual %0d",
					want.cells_updated, cu);
				errors++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	val_t     cfg_data;

	ogr_in_if  req_if ();
	ogr_out_if rsp_if ();

	grid_tracker tracker;
	int          sent_count = 0;
	int          idle_cycles = 0;
	int          settings = 0;
	bit          moved;
	coord_t      focus_col;
	coord_t      focus_row;

	occupancy_grid_ray_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always #1 clk = ~clk;

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 0;
			if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
				tracker.note_request('{kind: req_if.kind, col_a: req_if.col_a,
					row_a: req_if.row_a, col_b: req_if.col_b, row_b: req_if.row_b,
					is_hit: req_if.is_hit});
				moved = 1;
			end
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				tracker.check_response(rsp_if.cell_value, rsp_if.cells_updated);
				moved = 1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// response side: random stalls, bursts without stalls, two long hold-offs
	initial begin : rsp_side
		int cycles;
		int taken;
		taken = 0;
		rsp_if.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (taken == 150 || taken == 420)
				cycles = RSP_HOLD_CYCLES;
			else if ((taken % 60) >= 45)
				cycles = 0;
			else
				cycles = $urandom_range(0, 3);
			if (cycles != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (cycles) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(arst_n === 1'b1 && rsp_if.valid === 1'b1));
			taken++;
		end
	end

	function automatic grid_req_t ray(int c0, int r0, int c1, int r1, int hit);
		grid_req_t rq;
		rq.kind = KIND_RAY;
		rq.col_a = coord_t'(c0);
		rq.row_a = coord_t'(r0);
		rq.col_b = coord_t'(c1);
		rq.row_b = coord_t'(r1);
		rq.is_hit = (hit != 0);
		return rq;
	endfunction

	function automatic grid_req_t cell_read(int c, int r);
		grid_req_t rq;
		rq.kind = KIND_READ;
		rq.col_a = coord_t'(c);
		rq.row_a = coord_t'(r);
		rq.col_b = coord_t'($urandom);
		rq.row_b = coord_t'($urandom);
		rq.is_hit = ($urandom_range(0, 1) != 0);
		return rq;
	endfunction

	function automatic int near(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > GRID_COLS - 1) v = GRID_COLS - 1;
		return v;
	endfunction

	task automatic send(grid_req_t rq);
		int gap;
		gap = ((sent_count % 50) >= 40) ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.kind <= rq.kind;
		req_if.col_a <= rq.col_a;
		req_if.row_a <= rq.row_a;
		req_if.col_b <= rq.col_b;
		req_if.row_b <= rq.row_b;
		req_if.is_hit <= rq.is_hit;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sent_count++;
	endtask

	task automatic write_register(cfg_idx_t idx, val_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	task automatic apply_settings(val_t f, val_t o, val_t lo, val_t hi);
		write_register(CFG_FREE_INC, f);
		write_register(CFG_OCC_INC, o);
		write_register(CFG_LOWER, lo);
		write_register(CFG_UPPER, hi);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (tracker.pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_directed();
		grid_req_t items[$];
		items = '{cell_read(0, 0), cell_read(255, 255),
			ray(0, 0, 255, 0, 0), ray(0, 0, 0, 255, 1), ray(0, 0, 255, 255, 1),
			ray(255, 255, 0, 0, 0), ray(10, 10, 10, 10, 1), ray(10, 10, 10, 10, 0),
			ray(255, 0, 0, 255, 1), ray(5, 5, 6, 5, 1), ray(5, 5, 4, 5, 0),
			ray(20, 20, 23, 31, 0), ray(20, 20, 31, 17, 1), ray(40, 40, 33, 38, 0),
			ray(40, 40, 42, 29, 1), cell_read(255, 0), cell_read(0, 255),
			cell_read(1, 1), cell_read(6, 5), cell_read(4, 5), cell_read(128, 128),
			cell_read(254, 1), cell_read(23, 31), cell_read(10, 10)};
		foreach (items[i]) send(items[i]);
	endtask

	task automatic run_random(int count);
		int sel;
		int spread;
		int c, r;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					focus_col = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					focus_row = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end else begin
					focus_col = coord_t'($urandom);
					focus_row = coord_t'($urandom);
				end
			end
			sel = $urandom_range(0, 99);
			spread = $urandom_range(1, 12);
			if (sel < 55) begin
				c = near(focus_col, 2);
				r = near(focus_row, 2);
				send(ray(c, r, near(c, spread), near(r, spread), $urandom_range(0, 1)));
			end else if (sel < 70) begin
				send(cell_read(near(focus_col, 12), near(focus_row, 12)));
			end else if (sel < 80) begin
				send(ray($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1)));
			end else if (sel < 92) begin
				send(cell_read($urandom_range(0, 255), $urandom_range(0, 255)));
			end else begin
				c = $urandom_range(0, 255);
				r = $urandom_range(0, 255);
				send(ray(c, r, c, r, $urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FREE_INC;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_RAY;
		req_if.col_a = '0;
		req_if.row_a = '0;
		req_if.col_b = '0;
		req_if.row_b = '0;
		req_if.is_hit = 1'b0;
		focus_col = '0;
		focus_row = '0;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(FREE_INC_RST, OCC_INC_RST, LOWER_RST, UPPER_RST);
		run_directed();
		wait_idle();

		apply_settings(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		run_random(ITEMS_PER_PHASE);
		wait_idle();

		apply_settings(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
		run_random(ITEMS_PER_PHASE);
		wait_idle();

		// lower limit above upper limit
		apply_settings(-16'sd40, 16'sd90, 16'sd300, -16'sd300);
		run_random(ITEMS_PER_PHASE);
		wait_idle();

		// tight limits, saturation on nearly every revisit
		apply_settings(-16'sd3, 16'sd5, -16'sd12, 16'sd9);
		run_random(ITEMS_PER_PHASE);
		wait_idle();

		apply_settings(val_t'($urandom), val_t'($urandom),
			val_t'(-int'($urandom_range(0, 32768))), val_t'($urandom_range(0, 32767)));
		run_random(ITEMS_PER_PHASE);
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d rays (%0d hits, %0d zero length, longest %0d cells), %0d reads",
			tracker.rays, tracker.hits, tracker.flat_rays, tracker.longest, tracker.reads);
		$display("over %0d register settings with %0d saturated cell writes",
			settings, tracker.clamps);
		if (tracker.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
